### hw/rtl/wnm_pkg.sv
package wnm_pkg;

    localparam int THR_W   = 17;
    localparam int MUL_W   = 35;
    localparam int DIV_A_W = 64;
    localparam int DIV_B_W = 32;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic REPLY_DONE = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         det_index;
        logic [4:0]         word_index;
        logic signed [31:0] value;
        logic [6:0]         list_length;
    } req_t;

    typedef struct packed {
        logic               reply_kind;
        logic [6:0]         merged_count;
        logic signed [31:0] word_value;
        logic               in_range;
    } rsp_t;

endpackage

### hw/rtl/weighted_nms_merge.sv
// Weighted NMS merge. A load beat writes one word of a detection row; a read beat returns one
// merged word through the merged memory and the reply register. A compute beat sorts the first
// list_length rows by score and merges overlapping rows; it holds the input side until its reply
// is out. Everything goes through two-port detection and merged memories one word a cycle:
// the sort costs about n*n/2 score reads plus two reads and two writes per word of each swap,
// every pair tested for overlap reads four box words and then works out areas and the union
// test, every row joined to a group takes a read, a multiply and an add per word, and every
// merged word one pass of the serial divider, or a copy when the weight sum is zero.
module weighted_nms_merge #(
    parameter int MAX_DETECTIONS = 64,
    parameter int NUM_KEYPOINTS  = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [wnm_pkg::THR_W-1:0]   cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  wnm_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output wnm_pkg::rsp_t               rsp
);

    localparam int WORDS      = 4 + 2 * NUM_KEYPOINTS + 1;
    localparam int SCORE_WORD = WORDS - 1;
    localparam int DEPTH      = MAX_DETECTIONS * WORDS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ROW_W      = $clog2(MAX_DETECTIONS);
    localparam int CNT_W      = $clog2(MAX_DETECTIONS + 1);
    localparam int K_W        = $clog2(WORDS + 1);
    localparam int AK_W       = $clog2(SCORE_WORD);
    localparam int LOG_W      = $clog2(MAX_DETECTIONS);
    localparam int ACC_W      = 50 + LOG_W;
    localparam int SSUM_W     = 33 + LOG_W;
    localparam int WSUM_W     = 18 + LOG_W;
    localparam int MUL_W      = wnm_pkg::MUL_W;
    localparam int AREA_W     = 67;
    localparam int UNI_W      = 68;
    localparam int RHS_W      = 86;
    localparam int THR_W      = wnm_pkg::THR_W;
    localparam int WEIGHT_MAX = 65536;

    typedef enum logic [35:0] {
        ST_IDLE      = 36'h000000001,
        ST_RD_WAIT   = 36'h000000002,
        ST_SORT_CHKI = 36'h000000004,
        ST_SORT_STRT = 36'h000000008,
        ST_SORT_TOP  = 36'h000000010,
        ST_SORT_SCAN = 36'h000000020,
        ST_SORT_CHK  = 36'h000000040,
        ST_SWAP_RA   = 36'h000000080,
        ST_SWAP_RB   = 36'h000000100,
        ST_SWAP_WB   = 36'h000000200,
        ST_SWAP_WA   = 36'h000000400,
        ST_NMS_CHKI  = 36'h000000800,
        ST_NMS_STRT  = 36'h000001000,
        ST_NMS_ANC   = 36'h000002000,
        ST_ACC_RD    = 36'h000004000,
        ST_ACC_MUL   = 36'h000008000,
        ST_ACC_ADD   = 36'h000010000,
        ST_AREA_A    = 36'h000020000,
        ST_AREA_A_W  = 36'h000040000,
        ST_SCAN_NEXT = 36'h000080000,
        ST_SCAN_CHK  = 36'h000100000,
        ST_BOX_RD    = 36'h000200000,
        ST_BOX_CAP   = 36'h000400000,
        ST_OV_A      = 36'h000800000,
        ST_OV_B      = 36'h001000000,
        ST_OV_C      = 36'h002000000,
        ST_OV_D      = 36'h004000000,
        ST_OV_E      = 36'h008000000,
        ST_OV_F      = 36'h010000000,
        ST_OV_G      = 36'h020000000,
        ST_OUT_K     = 36'h040000000,
        ST_OUT_CPY   = 36'h080000000,
        ST_OUT_DIV   = 36'h100000000,
        ST_OUT_SCORE = 36'h200000000,
        ST_OUT_SDIV  = 36'h400000000,
        ST_FINISH    = 36'h800000000
    } state_t;

    function automatic logic [ADDR_W-1:0] addr_of(input int row, input int k);
        return ADDR_W'(row * WORDS + k);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    state_t state_reg, state_next;
    logic [THR_W-1:0]   thr_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   best_reg, best_next;
    logic [CNT_W-1:0]   out_reg, out_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               rsp_valid_reg;
    wnm_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_load;
    logic               rd_ok_reg, rd_ok_next;

    logic signed [31:0]     top_reg, top_next;
    logic [31:0]            tmp_reg, tmp_next;
    logic [16:0]            w_reg, w_next;
    logic signed [31:0]     s_reg, s_next;
    logic [WSUM_W-1:0]      wsum_reg, wsum_next;
    logic signed [SSUM_W-1:0] ssum_reg, ssum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [31:0]     box_a_reg [4];
    logic signed [31:0]     box_b_reg [4];
    logic signed [AREA_W-1:0] area_a_reg, area_a_next;
    logic signed [AREA_W-1:0] area_b_reg, area_b_next;
    logic signed [AREA_W-1:0] inter_reg, inter_next;
    logic signed [UNI_W-1:0]  uni_reg, uni_next;
    logic signed [MUL_W-1:0]  ow_reg, ow_next, oh_reg, oh_next;
    logic signed [2*MUL_W-1:0] lo_reg, lo_next;
    logic signed [RHS_W-1:0]  rhs_reg, rhs_next;
    logic signed [ACC_W-1:0]  acc_reg [SCORE_WORD];
    logic acc_clr, acc_add, box_a_cap, box_b_cap;

    logic                 det_we, mrg_we, mark_we, mark_wdata;
    logic [ADDR_W-1:0]    det_waddr, det_raddr, mrg_waddr, mrg_raddr;
    logic [31:0]          det_wdata, det_rdata, mrg_wdata, mrg_rdata;
    logic [ROW_W-1:0]     mark_waddr, mark_raddr;
    logic                 mark_rdata;
    logic signed [31:0]   det_rs;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic signed [wnm_pkg::DIV_A_W-1:0] div_a, div_q;
    logic [wnm_pkg::DIV_B_W-1:0]        div_b;

    logic                 accept;
    logic [CNT_W-1:0]     jn;
    logic signed [31:0]   mn_x, mx_x, mn_y, mx_y;
    logic signed [MUL_W-1:0] ow_raw, oh_raw;
    logic signed [RHS_W-1:0] lhs;

    assign det_rs    = $signed(det_rdata);
    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign jn        = j_reg + 1'b1;
    assign lhs       = RHS_W'(inter_reg) <<< 16;

    always_comb
    begin
        mn_x   = (box_a_reg[3] < box_b_reg[3]) ? box_a_reg[3] : box_b_reg[3];
        mx_x   = (box_a_reg[1] > box_b_reg[1]) ? box_a_reg[1] : box_b_reg[1];
        mn_y   = (box_a_reg[2] < box_b_reg[2]) ? box_a_reg[2] : box_b_reg[2];
        mx_y   = (box_a_reg[0] > box_b_reg[0]) ? box_a_reg[0] : box_b_reg[0];
        ow_raw = MUL_W'(mn_x) - MUL_W'(mx_x);
        oh_raw = MUL_W'(mn_y) - MUL_W'(mx_y);
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        best_next   = best_reg;
        out_next    = out_reg;
        total_next  = total_reg;
        k_next      = k_reg;
        rsp_next    = rsp_reg;
        rsp_load    = 1'b0;
        rd_ok_next  = rd_ok_reg;
        top_next    = top_reg;
        tmp_next    = tmp_reg;
        w_next      = w_reg;
        s_next      = s_reg;
        wsum_next   = wsum_reg;
        ssum_next   = ssum_reg;
        cnt_next    = cnt_reg;
        area_a_next = area_a_reg;
        area_b_next = area_b_reg;
        inter_next  = inter_reg;
        uni_next    = uni_reg;
        ow_next     = ow_reg;
        oh_next     = oh_reg;
        lo_next     = lo_reg;
        rhs_next    = rhs_reg;
        acc_clr     = 1'b0;
        acc_add     = 1'b0;
        box_a_cap   = 1'b0;
        box_b_cap   = 1'b0;
        det_we      = 1'b0;
        det_waddr   = '0;
        det_wdata   = '0;
        det_raddr   = '0;
        mrg_we      = 1'b0;
        mrg_waddr   = '0;
        mrg_wdata   = '0;
        mrg_raddr   = '0;
        mark_we     = 1'b0;
        mark_waddr  = '0;
        mark_wdata  = 1'b0;
        mark_raddr  = '0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_a       = '0;
        div_b       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        wnm_pkg::MODE_LOAD:
                        begin
                            if (int'(req.det_index) < MAX_DETECTIONS
                                && int'(req.word_index) < WORDS)
                            begin
                                det_we    = 1'b1;
                                det_waddr = addr_of(int'(req.det_index),
                                                    int'(req.word_index));
                                det_wdata = req.value;
                            end
                        end
                        wnm_pkg::MODE_COMPUTE:
                        begin
                            n_next     = (int'(req.list_length) > MAX_DETECTIONS)
                                         ? CNT_W'(MAX_DETECTIONS) : CNT_W'(req.list_length);
                            i_next     = '0;
                            out_next   = '0;
                            state_next = ST_SORT_CHKI;
                        end
                        wnm_pkg::MODE_READ:
                        begin
                            mrg_raddr  = addr_of(int'(req.det_index), int'(req.word_index));
                            rd_ok_next = int'(req.det_index) < int'(total_reg)
                                         && int'(req.det_index) < MAX_DETECTIONS
                                         && int'(req.word_index) < WORDS;
                            state_next = ST_RD_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                rsp_next.reply_kind   = wnm_pkg::REPLY_READ;
                rsp_next.merged_count = 7'(total_reg);
                rsp_next.word_value   = rd_ok_reg ? $signed(mrg_rdata) : 32'sd0;
                rsp_next.in_range     = rd_ok_reg;
                rsp_load              = 1'b1;
                state_next            = ST_IDLE;
            end

            // selection sort, first strict maximum wins
            ST_SORT_CHKI:
            begin
                if (i_reg < n_reg)
                begin
                    state_next = ST_SORT_STRT;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_NMS_CHKI;
                end
            end
            ST_SORT_STRT:
            begin
                det_raddr  = addr_of(int'(i_reg), SCORE_WORD);
                mark_we    = 1'b1;
                mark_waddr = i_reg[ROW_W-1:0];
                mark_wdata = 1'b0;
                state_next = ST_SORT_TOP;
            end
            ST_SORT_TOP:
            begin
                top_next  = det_rs;
                best_next = i_reg;
                if ((i_reg + 1'b1) < n_reg)
                begin
                    j_next     = i_reg + 1'b1;
                    det_raddr  = addr_of(int'(i_reg) + 1, SCORE_WORD);
                    state_next = ST_SORT_SCAN;
                end
                else
                begin
                    state_next = ST_SORT_CHK;
                end
            end
            ST_SORT_SCAN:
            begin
                if (det_rs > top_reg)
                begin
                    top_next  = det_rs;
                    best_next = j_reg;
                end
                if (jn < n_reg)
                begin
                    j_next    = jn;
                    det_raddr = addr_of(int'(jn), SCORE_WORD);
                end
                else
                begin
                    state_next = ST_SORT_CHK;
                end
            end
            ST_SORT_CHK:
            begin
                if (best_reg != i_reg)
                begin
                    k_next     = '0;
                    state_next = ST_SWAP_RA;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SORT_CHKI;
                end
            end
            ST_SWAP_RA:
            begin
                det_raddr  = addr_of(int'(i_reg), int'(k_reg));
                state_next = ST_SWAP_RB;
            end
            ST_SWAP_RB:
            begin
                tmp_next   = det_rdata;
                det_raddr  = addr_of(int'(best_reg), int'(k_reg));
                state_next = ST_SWAP_WB;
            end
            ST_SWAP_WB:
            begin
                det_we     = 1'b1;
                det_waddr  = addr_of(int'(i_reg), int'(k_reg));
                det_wdata  = det_rdata;
                state_next = ST_SWAP_WA;
            end
            ST_SWAP_WA:
            begin
                det_we    = 1'b1;
                det_waddr = addr_of(int'(best_reg), int'(k_reg));
                det_wdata = tmp_reg;
                k_next    = k_reg + 1'b1;
                if (int'(k_reg) + 1 == WORDS)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SORT_CHKI;
                end
                else
                begin
                    state_next = ST_SWAP_RA;
                end
            end

            // merge walk over the sorted rows
            ST_NMS_CHKI:
            begin
                state_next = (i_reg < n_reg) ? ST_NMS_STRT : ST_FINISH;
            end
            ST_NMS_STRT:
            begin
                det_raddr  = addr_of(int'(i_reg), SCORE_WORD);
                mark_raddr = i_reg[ROW_W-1:0];
                state_next = ST_NMS_ANC;
            end
            ST_NMS_ANC:
            begin
                // a negative score counts as suppressed from the start
                if (mark_rdata || det_rs < 0)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_NMS_CHKI;
                end
                else
                begin
                    acc_clr    = 1'b1;
                    wsum_next  = '0;
                    ssum_next  = '0;
                    cnt_next   = '0;
                    j_next     = i_reg;
                    s_next     = det_rs;
                    w_next     = (det_rs > WEIGHT_MAX) ? 17'(WEIGHT_MAX) : det_rs[16:0];
                    k_next     = '0;
                    state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD:
            begin
                det_raddr  = addr_of(int'(j_reg), int'(k_reg));
                state_next = ST_ACC_MUL;
            end
            ST_ACC_MUL:
            begin
                mul_a = MUL_W'(det_rs);
                mul_b = $signed(MUL_W'(w_reg));
                if (j_reg == i_reg && int'(k_reg) < 4)
                begin
                    box_a_cap = 1'b1;
                end
                state_next = ST_ACC_ADD;
            end
            ST_ACC_ADD:
            begin
                acc_add = 1'b1;
                if (int'(k_reg) + 1 < SCORE_WORD)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    k_next     = '0;
                    wsum_next  = wsum_reg + WSUM_W'(w_reg);
                    ssum_next  = ssum_reg + SSUM_W'(s_reg);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = (j_reg == i_reg) ? ST_AREA_A : ST_SCAN_NEXT;
                end
            end
            ST_AREA_A:
            begin
                mul_a      = MUL_W'(box_a_reg[3]) - MUL_W'(box_a_reg[1]);
                mul_b      = MUL_W'(box_a_reg[2]) - MUL_W'(box_a_reg[0]);
                state_next = ST_AREA_A_W;
            end
            ST_AREA_A_W:
            begin
                area_a_next = mul_p[AREA_W-1:0];
                state_next  = ST_SCAN_NEXT;
            end
            ST_SCAN_NEXT:
            begin
                k_next = '0;
                if (jn < n_reg)
                begin
                    j_next     = jn;
                    det_raddr  = addr_of(int'(jn), SCORE_WORD);
                    mark_raddr = jn[ROW_W-1:0];
                    state_next = ST_SCAN_CHK;
                end
                else
                begin
                    state_next = ST_OUT_K;
                end
            end
            ST_SCAN_CHK:
            begin
                if (mark_rdata || det_rs < 0)
                begin
                    state_next = ST_SCAN_NEXT;
                end
                else
                begin
                    s_next     = det_rs;
                    w_next     = (det_rs > WEIGHT_MAX) ? 17'(WEIGHT_MAX) : det_rs[16:0];
                    state_next = ST_BOX_RD;
                end
            end
            ST_BOX_RD:
            begin
                det_raddr  = addr_of(int'(j_reg), 0);
                k_next     = '0;
                state_next = ST_BOX_CAP;
            end
            ST_BOX_CAP:
            begin
                box_b_cap = 1'b1;
                k_next    = k_reg + 1'b1;
                if (int'(k_reg) < 3)
                begin
                    det_raddr = addr_of(int'(j_reg), int'(k_reg) + 1);
                end
                else
                begin
                    state_next = ST_OV_A;
                end
            end
            ST_OV_A:
            begin
                ow_next    = ow_raw[MUL_W-1] ? '0 : ow_raw;
                oh_next    = oh_raw[MUL_W-1] ? '0 : oh_raw;
                mul_a      = MUL_W'(box_b_reg[3]) - MUL_W'(box_b_reg[1]);
                mul_b      = MUL_W'(box_b_reg[2]) - MUL_W'(box_b_reg[0]);
                state_next = ST_OV_B;
            end
            ST_OV_B:
            begin
                area_b_next = mul_p[AREA_W-1:0];
                mul_a       = ow_reg;
                mul_b       = oh_reg;
                state_next  = ST_OV_C;
            end
            ST_OV_C:
            begin
                inter_next = mul_p[AREA_W-1:0];
                uni_next   = UNI_W'(area_a_reg) + UNI_W'(area_b_reg)
                             - UNI_W'(mul_p[AREA_W-1:0]);
                state_next = ST_OV_D;
            end
            ST_OV_D:
            begin
                // union times threshold in two halves of the union
                mul_a      = $signed({2'b00, uni_reg[32:0]});
                mul_b      = $signed(MUL_W'(thr_reg));
                state_next = ST_OV_E;
            end
            ST_OV_E:
            begin
                lo_next    = mul_p;
                mul_a      = uni_reg[UNI_W-1:33];
                mul_b      = $signed(MUL_W'(thr_reg));
                state_next = ST_OV_F;
            end
            ST_OV_F:
            begin
                rhs_next   = (RHS_W'(mul_p) <<< 33) + RHS_W'(lo_reg);
                state_next = ST_OV_G;
            end
            ST_OV_G:
            begin
                if (lhs > rhs_reg)
                begin
                    mark_we    = 1'b1;
                    mark_waddr = j_reg[ROW_W-1:0];
                    mark_wdata = 1'b1;
                    k_next     = '0;
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    state_next = ST_SCAN_NEXT;
                end
            end

            // write out one merged row
            ST_OUT_K:
            begin
                if (int'(k_reg) == SCORE_WORD)
                begin
                    state_next = ST_OUT_SCORE;
                end
                else if (wsum_reg == '0)
                begin
                    det_raddr  = addr_of(int'(i_reg), int'(k_reg));
                    state_next = ST_OUT_CPY;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = wnm_pkg::DIV_A_W'(acc_reg[k_reg[AK_W-1:0]]);
                    div_b      = wnm_pkg::DIV_B_W'(wsum_reg);
                    state_next = ST_OUT_DIV;
                end
            end
            ST_OUT_CPY:
            begin
                mrg_we     = 1'b1;
                mrg_waddr  = addr_of(int'(out_reg), int'(k_reg));
                mrg_wdata  = det_rdata;
                k_next     = k_reg + 1'b1;
                state_next = ST_OUT_K;
            end
            ST_OUT_DIV:
            begin
                if (div_done)
                begin
                    mrg_we     = 1'b1;
                    mrg_waddr  = addr_of(int'(out_reg), int'(k_reg));
                    mrg_wdata  = sat32(div_q);
                    k_next     = k_reg + 1'b1;
                    state_next = ST_OUT_K;
                end
            end
            ST_OUT_SCORE:
            begin
                div_start  = 1'b1;
                div_a      = wnm_pkg::DIV_A_W'(ssum_reg);
                div_b      = wnm_pkg::DIV_B_W'(cnt_reg);
                state_next = ST_OUT_SDIV;
            end
            ST_OUT_SDIV:
            begin
                if (div_done)
                begin
                    mrg_we     = 1'b1;
                    mrg_waddr  = addr_of(int'(out_reg), SCORE_WORD);
                    mrg_wdata  = sat32(div_q);
                    out_next   = out_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_NMS_CHKI;
                end
            end
            ST_FINISH:
            begin
                total_next            = out_reg;
                rsp_next.reply_kind   = wnm_pkg::REPLY_DONE;
                rsp_next.merged_count = 7'(out_reg);
                rsp_next.word_value   = 32'sd0;
                rsp_next.in_range     = 1'b0;
                rsp_load              = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_W'(19661);
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            best_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            total_reg <= total_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            n_reg    <= n_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
            best_reg <= best_next;
            out_reg  <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        rd_ok_reg  <= rd_ok_next;
        top_reg    <= top_next;
        tmp_reg    <= tmp_next;
        w_reg      <= w_next;
        s_reg      <= s_next;
        wsum_reg   <= wsum_next;
        ssum_reg   <= ssum_next;
        cnt_reg    <= cnt_next;
        area_a_reg <= area_a_next;
        area_b_reg <= area_b_next;
        inter_reg  <= inter_next;
        uni_reg    <= uni_next;
        ow_reg     <= ow_next;
        oh_reg     <= oh_next;
        lo_reg     <= lo_next;
        rhs_reg    <= rhs_next;
        if (box_a_cap)
        begin
            box_a_reg[k_reg[1:0]] <= det_rs;
        end
        if (box_b_cap)
        begin
            box_b_reg[k_reg[1:0]] <= det_rs;
        end
        if (acc_clr)
        begin
            for (int m = 0; m < SCORE_WORD; m++)
            begin
                acc_reg[m] <= '0;
            end
        end
        else if (acc_add)
        begin
            acc_reg[k_reg[AK_W-1:0]] <= acc_reg[k_reg[AK_W-1:0]] + mul_p[ACC_W-1:0];
        end
    end

    wnm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_det_ram (
        .clk   (clk),
        .we    (det_we),
        .waddr (det_waddr),
        .wdata (det_wdata),
        .raddr (det_raddr),
        .rdata (det_rdata)
    );

    wnm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mrg_ram (
        .clk   (clk),
        .we    (mrg_we),
        .waddr (mrg_waddr),
        .wdata (mrg_wdata),
        .raddr (mrg_raddr),
        .rdata (mrg_rdata)
    );

    wnm_ram #(.WIDTH(1), .DEPTH(MAX_DETECTIONS)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    wnm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    wnm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

### hw/rtl/wnm_ram.sv
module wnm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1088,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/wnm_mul.sv
module wnm_mul (
    input  logic                                 clk,
    input  logic signed [wnm_pkg::MUL_W-1:0]     a,
    input  logic signed [wnm_pkg::MUL_W-1:0]     b,
    output logic signed [2*wnm_pkg::MUL_W-1:0]   p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

### hw/rtl/wnm_div.sv
module wnm_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [wnm_pkg::DIV_A_W-1:0]  dividend,
    input  logic [wnm_pkg::DIV_B_W-1:0]         divisor,
    output logic                                done,
    output logic signed [wnm_pkg::DIV_A_W-1:0]  quotient
);

    localparam int AW = wnm_pkg::DIV_A_W;
    localparam int BW = wnm_pkg::DIV_B_W;
    localparam int CW = $clog2(AW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [AW-1:0] quo_reg;
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] div_reg;
    logic          neg_reg;
    logic [BW:0]   rem_sh;
    logic [BW:0]   rem_new;
    logic          ge;
    logic [AW-1:0] mag;

    always_comb
    begin
        mag     = dividend[AW-1] ? (AW'(0) - AW'(dividend)) : AW'(dividend);
        rem_sh  = {rem_reg, quo_reg[AW-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_new = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(AW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit a cycle on the magnitude, sign put back at the end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[AW-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[AW-2:0], ge};
            rem_reg <= rem_new[BW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(AW'(0) - quo_reg) : $signed(quo_reg);

endmodule
